/* design/bsss_pkg.sv */
package bsss_pkg;

    // store depth, 1 to 64
    localparam int DEPTH   = 64;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 14;
    localparam int ROT_W   = $clog2(DEPTH + 1);

    // cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_ROTATE = 2'd2;

    typedef logic [1:0] t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [7:0]  sample;
    } t_cell_ctl;

endpackage

/* design/bsss_cell.sv */
module bsss_cell (
    input  logic                 i_clk,
    input  bsss_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_active,
    input  logic                 i_prev_kept,
    input  logic [7:0]           i_prev_val,
    input  logic [7:0]           i_next_val,
    output logic                 o_kept,
    output logic [7:0]           o_val
);
    import bsss_pkg::*;

    logic [7:0] r_val;
    logic [7:0] n_val;

    // a valid cell keeps its byte if it is not below the incoming one
    assign o_kept = i_active && (r_val >= i_ctl.sample);
    assign o_val  = r_val;

    always_comb begin
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (o_kept) begin
                    n_val = r_val;
                end else if (i_prev_kept) begin
                    n_val = i_ctl.sample;
                end else begin
                    n_val = i_prev_val;
                end
            end
            CELL_ROTATE: n_val = i_next_val;
            default:     n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* design/bsss_div.sv */
module bsss_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [bsss_pkg::SUM_W-1:0]    i_dividend,
    input  logic [bsss_pkg::COUNT_W-1:0]  i_divisor,
    output logic                          o_busy,
    output logic [bsss_pkg::SUM_W-1:0]    o_quot
);
    import bsss_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]   r_quot;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [STEP_W-1:0]  r_steps;
    logic               r_busy;
    logic [COUNT_W:0]   trial;
    logic               fits;

    // shift one dividend bit into the partial remainder
    assign trial = {r_rem, r_quot[SUM_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_go) begin
            r_busy  <= 1'b1;
            r_steps <= STEP_W'(SUM_W);
            r_quot  <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_steps <= r_steps - 1'b1;
            r_busy  <= (r_steps != STEP_W'(1));
            r_quot  <= {r_quot[SUM_W-2:0], fits};
            r_rem   <= fits ? COUNT_W'(trial - {1'b0, r_div}) : trial[COUNT_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* design/byte_set_statistics_sorter_top.sv */
// Collects a set of unsigned bytes, one transfer per cycle while busy is low;
// final_item closes the set. Bytes are sorted descending on arrival by a chain
// of DEPTH cells. On close the block goes busy: the chain rotates once through
// all DEPTH cells to pick out the median pair while a restoring divider (one
// quotient bit per cycle) forms the mean. Then one result per stored byte is
// strobed on o_valid in consecutive cycles, largest first. The receiver cannot
// stall: each result is on the ports for exactly one cycle. Bytes beyond DEPTH
// are dropped and flagged by o_overflowed.
module byte_set_statistics_sorter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_sample,
    input  logic       i_final_item,
    output logic       o_valid,
    output logic [7:0] o_sorted_value,
    output logic [5:0] o_rank,
    output logic       o_end_of_run,
    output logic [7:0] o_largest,
    output logic [7:0] o_smallest,
    output logic [7:0] o_average,
    output logic [7:0] o_middle,
    output logic       o_overflowed
);
    import bsss_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_STAT = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]         r_state;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [7:0]         r_max;
    logic [7:0]         r_min;
    logic               r_ovf;
    logic [ROT_W-1:0]   r_rot;
    logic [5:0]         r_rank;
    logic               r_div_go;
    logic [7:0]         r_med_lo;
    logic [7:0]         r_med_hi;
    logic [7:0]         r_average;
    logic [7:0]         r_middle;

    logic               accept;
    logic               room;
    logic               last_out;
    logic               div_busy;
    logic [SUM_W-1:0]   div_quot;
    logic [COUNT_W-1:0] lo_idx;
    logic [COUNT_W-1:0] hi_idx;
    logic [8:0]         med_sum;
    t_cell_ctl          cell_ctl;

    logic [7:0]         cell_val  [DEPTH];
    logic               cell_kept [DEPTH];

    assign accept   = start && !busy;
    assign room     = r_count < COUNT_W'(DEPTH);
    assign busy     = (r_state != ST_LOAD);
    assign last_out = ({1'b0, r_rank} == r_count - 1'b1);
    assign lo_idx   = (r_count - 1'b1) >> 1;
    assign hi_idx   = r_count >> 1;
    assign med_sum  = {1'b0, r_med_lo} + {1'b0, r_med_hi};

    // chain control: insert on a stored transfer, rotate while scanning or emitting
    always_comb begin
        cell_ctl.sample = i_sample;
        if (accept && room) begin
            cell_ctl.op = CELL_INSERT;
        end else if ((r_state == ST_STAT && r_rot != ROT_W'(DEPTH)) || r_state == ST_OUT) begin
            cell_ctl.op = CELL_ROTATE;
        end else begin
            cell_ctl.op = CELL_HOLD;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic       prev_kept;
        logic [7:0] prev_val;
        logic [7:0] next_val;

        if (g == 0) begin : g_head
            assign prev_kept = 1'b1;
            assign prev_val  = i_sample;
        end else begin : g_body
            assign prev_kept = cell_kept[g-1];
            assign prev_val  = cell_val[g-1];
        end
        assign next_val = cell_val[(g + 1) % DEPTH];

        bsss_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_active    (r_count > COUNT_W'(g)),
            .i_prev_kept (prev_kept),
            .i_prev_val  (prev_val),
            .i_next_val  (next_val),
            .o_kept      (cell_kept[g]),
            .o_val       (cell_val[g])
        );
    end

    bsss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_sum    <= '0;
            r_max    <= 8'd0;
            r_min    <= 8'd255;
            r_ovf    <= 1'b0;
            r_rot    <= '0;
            r_rank   <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (room) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + SUM_W'(i_sample);
                            if (i_sample > r_max) begin
                                r_max <= i_sample;
                            end
                            if (i_sample < r_min) begin
                                r_min <= i_sample;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_final_item) begin
                            r_state  <= ST_STAT;
                            r_rot    <= '0;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                ST_STAT: begin
                    // after k rotations cell 0 holds the element of rank k
                    if (r_rot != ROT_W'(DEPTH)) begin
                        r_rot <= r_rot + 1'b1;
                        if (COUNT_W'(r_rot) == lo_idx) begin
                            r_med_lo <= cell_val[0];
                        end
                        if (COUNT_W'(r_rot) == hi_idx) begin
                            r_med_hi <= cell_val[0];
                        end
                    end else if (!div_busy && !r_div_go) begin
                        r_average <= div_quot[7:0];
                        r_middle  <= med_sum[8:1];
                        r_rank    <= '0;
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_rank <= r_rank + 1'b1;
                    if (last_out) begin
                        r_state <= ST_LOAD;
                        r_count <= '0;
                        r_sum   <= '0;
                        r_max   <= 8'd0;
                        r_min   <= 8'd255;
                        r_ovf   <= 1'b0;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_valid        = (r_state == ST_OUT);
    assign o_sorted_value = cell_val[0];
    assign o_rank         = r_rank;
    assign o_end_of_run   = o_valid && last_out;
    assign o_largest      = r_max;
    assign o_smallest     = r_min;
    assign o_average      = r_average;
    assign o_middle       = r_middle;
    assign o_overflowed   = r_ovf;

`ifndef SYNTHESIS
    // the store count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(DEPTH))
        else $error("element count above depth");

    // ranks climb by one within a run
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_run |=> o_valid && o_rank == $past(o_rank) + 6'd1)
        else $error("rank sequence broken");

    // the last result frees the block
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_run |=> !busy && r_count == '0)
        else $error("block not cleared after run");

    // the divider is idle by the time results are emitted
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !div_busy)
        else $error("mean not ready during output");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bsss_pkg::*;

    // one byte transfer into the block
    typedef struct {
        logic [7:0] sample;
        logic       final_item;
    } t_byte_xfer;

    // one sorted element with the statistics of its set
    typedef struct {
        logic [7:0] sorted_value;
        logic [5:0] rank;
        logic       end_of_run;
        logic [7:0] largest;
        logic [7:0] smallest;
        logic [7:0] average;
        logic [7:0] middle;
        logic       overflowed;
    } t_ranked_byte;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BYTES = 350;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_sample;
    logic       i_final_item;
    logic       o_valid;
    logic [7:0] o_sorted_value;
    logic [5:0] o_rank;
    logic       o_end_of_run;
    logic [7:0] o_largest;
    logic [7:0] o_smallest;
    logic [7:0] o_average;
    logic [7:0] o_middle;
    logic       o_overflowed;

    byte_set_statistics_sorter_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_rank         (o_rank),
        .o_end_of_run   (o_end_of_run),
        .o_largest      (o_largest),
        .o_smallest     (o_smallest),
        .o_average      (o_average),
        .o_middle       (o_middle),
        .o_overflowed   (o_overflowed)
    );

    // bytes waiting to be sent, and sorted elements still owed by the block
    t_byte_xfer   pending_bytes[$];
    t_ranked_byte sorted_due[$];

    // predictor copy of the set being collected
    logic [7:0]  set_bytes[DEPTH];
    int unsigned set_count;
    logic [13:0] set_sum;
    logic [7:0]  set_max;
    logic [7:0]  set_min;
    logic        set_overflow;

    int unsigned cycle_count;
    int unsigned total_bytes;
    int unsigned sent_bytes;
    int unsigned sets_closed;
    int unsigned overflow_sets;
    int unsigned results_checked;
    int unsigned mismatch_count;
    logic        taken;

    // clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // queue one byte for the driver
    task automatic push_byte(input logic [7:0] b, input logic last);
        t_byte_xfer x;
        x.sample     = b;
        x.final_item = last;
        pending_bytes.push_back(x);
        total_bytes++;
    endtask

    // queue a whole set of random bytes; flavor picks the value spread
    task automatic push_random_set(input int unsigned len);
        int unsigned flavor;
        int unsigned k;
        logic [7:0]  b;
        flavor = $urandom_range(0, 3);
        for (k = 0; k < len; k++) begin
            case (flavor)
                0: b = 8'($urandom_range(0, 3));           // heavy duplicates
                1: b = $urandom_range(0, 1) ? 8'hff : 8'h00;
                default: b = 8'($urandom_range(0, 255));
            endcase
            push_byte(b, k == len - 1);
        end
    endtask

    // return the collected set to its empty state
    task automatic clear_set();
        set_count    = 0;
        set_sum      = '0;
        set_max      = 8'd0;
        set_min      = 8'd255;
        set_overflow = 1'b0;
    endtask

    // absorb one accepted byte; on the closing byte, work out every sorted element
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [7:0]   ordered[DEPTH];
        logic [7:0]   key;
        int unsigned  n;
        int unsigned  i;
        int unsigned  j;
        logic [7:0]   mean;
        logic [7:0]   med;
        t_ranked_byte r;
        if (set_count < DEPTH) begin
            set_bytes[set_count] = b;
            set_count++;
            set_sum = set_sum + 14'(b);
            if (b > set_max) set_max = b;
            if (b < set_min) set_min = b;
        end else begin
            set_overflow = 1'b1;
        end
        if (last) begin
            n = set_count;
            for (i = 0; i < n; i++) ordered[i] = set_bytes[i];
            // insertion sort, largest first
            for (i = 1; i < n; i++) begin
                key = ordered[i];
                j   = i;
                while (j > 0 && ordered[j - 1] < key) begin
                    ordered[j] = ordered[j - 1];
                    j--;
                end
                ordered[j] = key;
            end
            mean = 8'(32'(set_sum) / n);
            if (n % 2 == 0)
                med = 8'((32'(ordered[n / 2]) + 32'(ordered[(n - 1) / 2])) / 2);
            else
                med = ordered[n / 2];
            for (i = 0; i < n; i++) begin
                r.sorted_value = ordered[i];
                r.rank         = 6'(i);
                r.end_of_run   = (i + 1 == n);
                r.largest      = set_max;
                r.smallest     = set_min;
                r.average      = mean;
                r.middle       = med;
                r.overflowed   = set_overflow;
                sorted_due.push_back(r);
            end
            sets_closed++;
            if (set_overflow) overflow_sets++;
            clear_set();
        end
    endtask

    // driver: presents the next byte at the falling edge once the last one was taken;
    // sender idles 9% in the first third, 81% in the second, never in the last
    always @(negedge i_clk) begin
        t_byte_xfer  x;
        int unsigned idle_pct;
        if (i_rst_n) begin
            if (!start || taken) begin
                if (sent_bytes * 3 < total_bytes)          idle_pct = 9;
                else if (sent_bytes * 3 < total_bytes * 2) idle_pct = 81;
                else                                       idle_pct = 0;
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    x = pending_bytes.pop_front();
                    start        <= 1'b1;
                    i_sample     <= x.sample;
                    i_final_item <= x.final_item;
                    sent_bytes++;
                end else begin
                    // idle: junk on the data lines must be ignored
                    start        <= 1'b0;
                    i_sample     <= 8'($urandom_range(0, 255));
                    i_final_item <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    // monitor: samples the handshake and the result strobe at the rising edge
    always @(posedge i_clk) begin
        t_ranked_byte want;
        cycle_count++;
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            taken <= start && !busy;
            if (start && !busy) absorb_byte(i_sample, i_final_item);
            if (o_valid) begin
                results_checked++;
                if (sorted_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: value %0d rank %0d",
                                 o_sorted_value, o_rank);
                end else begin
                    want = sorted_due.pop_front();
                    if (o_sorted_value !== want.sorted_value || o_rank !== want.rank ||
                        o_end_of_run !== want.end_of_run || o_largest !== want.largest ||
                        o_smallest !== want.smallest || o_average !== want.average ||
                        o_middle !== want.middle || o_overflowed !== want.overflowed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch at cycle %0d", cycle_count);
                            $display("  expected val %0d rank %0d end %0d max %0d min %0d",
                                     want.sorted_value, want.rank, want.end_of_run,
                                     want.largest, want.smallest);
                            $display("           avg %0d med %0d ovf %0d",
                                     want.average, want.middle, want.overflowed);
                            $display("  actual   val %0d rank %0d end %0d max %0d min %0d",
                                     o_sorted_value, o_rank, o_end_of_run,
                                     o_largest, o_smallest);
                            $display("           avg %0d med %0d ovf %0d",
                                     o_average, o_middle, o_overflowed);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned random_start;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_sample        = 8'd0;
        i_final_item    = 1'b0;
        taken           = 1'b0;
        cycle_count     = 0;
        total_bytes     = 0;
        sent_bytes      = 0;
        sets_closed     = 0;
        overflow_sets   = 0;
        results_checked = 0;
        mismatch_count  = 0;
        clear_set();

        // directed sets: single byte at both extremes, even and odd counts,
        // duplicates, ascending and descending input order
        push_byte(8'd0, 1'b1);
        push_byte(8'd255, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'd0, 1'b1);
        push_byte(8'd7, 1'b0);
        push_byte(8'd200, 1'b0);
        push_byte(8'd7, 1'b1);
        push_byte(8'd1, 1'b0);
        push_byte(8'd2, 1'b0);
        push_byte(8'd3, 1'b0);
        push_byte(8'd4, 1'b1);
        push_byte(8'd9, 1'b0);
        push_byte(8'd8, 1'b0);
        push_byte(8'd7, 1'b0);
        push_byte(8'd6, 1'b0);
        push_byte(8'd5, 1'b1);
        push_byte(8'd255, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd254, 1'b0);
        push_byte(8'd254, 1'b0);
        push_byte(8'd1, 1'b0);
        push_byte(8'd0, 1'b1);

        // random sets: exactly full, closing byte dropped, well past full,
        // then mostly short sets with an occasional long one
        random_start = total_bytes;
        push_random_set(DEPTH);
        push_random_set(DEPTH + 1);
        push_random_set(DEPTH + 6);
        while (total_bytes - random_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 11) == 0)
                push_random_set($urandom_range(DEPTH - 4, DEPTH + 8));
            else
                push_random_set($urandom_range(1, 12));
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || start) @(posedge i_clk);
        while (sorted_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d sets, %0d of them overflowing the store",
                 sent_bytes, sets_closed, overflow_sets);
        $display("checked %0d sorted results, %0d mismatches", results_checked,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/bsss_pkg.sv
design/bsss_cell.sv
design/bsss_div.sv
design/byte_set_statistics_sorter_top.sv
tb/sv/testbench.sv
